// ===== rtl/assert_macros.svh =====
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// ===== rtl/eplc_pkg.sv =====
// shared widths, codes, reset values and beat types of the encoder position block
// no dependencies
package eplc_pkg;

	localparam int COUNT_WIDTH_DEF = 32;

	localparam int OP_W       = 3;
	localparam int TIME_W     = 32;
	localparam int DEB_W      = 32;
	localparam int ZONE_W     = 16;
	localparam int SCALE_W    = 24;
	localparam int POS_W      = 32;
	localparam int LEN_W      = 31;
	localparam int SPEED_W    = 48;
	localparam int EV_W       = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	// operation codes
	localparam logic [OP_W-1:0] OP_EDGE  = 3'd0;
	localparam logic [OP_W-1:0] OP_SW_A  = 3'd1;
	localparam logic [OP_W-1:0] OP_SW_B  = 3'd2;
	localparam logic [OP_W-1:0] OP_TICK  = 3'd3;
	localparam logic [OP_W-1:0] OP_CALIB = 3'd4;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SLOW_ZONE   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SPEED_SCALE = 2'd2;

	localparam logic [DEB_W-1:0]   DEBOUNCE_RST    = 32'd200000;
	localparam logic [ZONE_W-1:0]  SLOW_ZONE_RST   = 16'd200;
	localparam logic [SCALE_W-1:0] SPEED_SCALE_RST = 24'd82783;

	// calibration events
	localparam logic [EV_W-1:0] EV_NONE      = 2'd0;
	localparam logic [EV_W-1:0] EV_FIRST_END = 2'd1;
	localparam logic [EV_W-1:0] EV_LENGTH    = 2'd2;

	localparam logic [LEN_W-1:0] LEN_MAX = 31'h7FFF_FFFF;

	typedef struct packed {
		logic [OP_W-1:0]   operation;
		logic              level_a;
		logic              level_b;
		logic [TIME_W-1:0] time_us;
	} item_t;

	typedef struct packed {
		logic                      calibrating;
		logic signed [POS_W-1:0]   position;
		logic [LEN_W-1:0]          rope_length;
		logic signed [POS_W-1:0]   period_pulses;
		logic signed [SPEED_W-1:0] speed_um_s;
		logic                      speed_valid;
		logic                      slow_cw;
		logic                      slow_ccw;
		logic                      stop_a;
		logic                      stop_b;
		logic                      halt_pulse;
		logic [EV_W-1:0]           calib_event;
	} result_t;

	typedef struct packed {
		logic [DEB_W-1:0]   debounce_us;
		logic [ZONE_W-1:0]  slow_zone_pulses;
		logic [SCALE_W-1:0] speed_scale_q8;
	} cfg_t;

endpackage

// ===== rtl/eplc_if.sv =====
// valid/ready channel interfaces for event beats and result beats
// depends on eplc_pkg
interface eplc_in_if import eplc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   operation;
	logic              level_a;
	logic              level_b;
	logic [TIME_W-1:0] time_us;

	modport source(output valid, operation, level_a, level_b, time_us, input ready);
	modport sink(input valid, operation, level_a, level_b, time_us, output ready);
endinterface

interface eplc_out_if import eplc_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic                      calibrating;
	logic signed [POS_W-1:0]   position;
	logic [LEN_W-1:0]          rope_length;
	logic signed [POS_W-1:0]   period_pulses;
	logic signed [SPEED_W-1:0] speed_um_s;
	logic                      speed_valid;
	logic                      slow_cw;
	logic                      slow_ccw;
	logic                      stop_a;
	logic                      stop_b;
	logic                      halt_pulse;
	logic [EV_W-1:0]           calib_event;

	modport source(output valid, calibrating, position, rope_length, period_pulses,
		speed_um_s, speed_valid, slow_cw, slow_ccw, stop_a, stop_b, halt_pulse,
		calib_event, input ready);
	modport sink(input valid, calibrating, position, rope_length, period_pulses,
		speed_um_s, speed_valid, slow_cw, slow_ccw, stop_a, stop_b, halt_pulse,
		calib_event, output ready);
endinterface

// ===== rtl/encoder_position_limit_controller.sv =====
// an accepted event beat passes the event register, then the result register,
// before it leaves as its result beat
// throughput: one event per cycle; both registers stall together on a held output
// the combinational path is the state update plus the 32x24 speed multiply in eplc_core
// reset: arst_n clears counts, calibration, stop latches, slow flags and press times,
// loads the register defaults and empties both pipeline registers
module encoder_position_limit_controller import eplc_pkg::*; #(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	eplc_in_if.sink               items,
	eplc_out_if.source            results
);

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	result_t res_next;
	result_t res_q;
	logic    out_valid_q;
	logic    accept;
	logic    advance;

	// register file
	eplc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// event in stage one moves on when the result register is empty or being drained
	assign advance     = valid_s1 && (!out_valid_q || results.ready);
	assign items.ready = !valid_s1 || advance;
	assign accept      = items.valid && items.ready;

	// event register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.operation <= items.operation;
			item_s1.level_a   <= items.level_a;
			item_s1.level_b   <= items.level_b;
			item_s1.time_us   <= items.time_us;
		end
	end

	// state commits exactly when the event leaves stage one, so the next event sees it
	eplc_core #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res_next)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_next;
		end
	end

	assign results.valid         = out_valid_q;
	assign results.calibrating   = res_q.calibrating;
	assign results.position      = res_q.position;
	assign results.rope_length   = res_q.rope_length;
	assign results.period_pulses = res_q.period_pulses;
	assign results.speed_um_s    = res_q.speed_um_s;
	assign results.speed_valid   = res_q.speed_valid;
	assign results.slow_cw       = res_q.slow_cw;
	assign results.slow_ccw      = res_q.slow_ccw;
	assign results.stop_a        = res_q.stop_a;
	assign results.stop_b        = res_q.stop_b;
	assign results.halt_pulse    = res_q.halt_pulse;
	assign results.calib_event   = res_q.calib_event;

endmodule

// ===== rtl/eplc_cfg.sv =====
// configuration register file: debounce time, slow-zone distance, speed scale
// depends on eplc_pkg
module eplc_cfg import eplc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_us      <= DEBOUNCE_RST;
			cfg_q.slow_zone_pulses <= SLOW_ZONE_RST;
			cfg_q.speed_scale_q8   <= SPEED_SCALE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_DEBOUNCE:    cfg_q.debounce_us      <= cfg_data[DEB_W-1:0];
				CFG_SLOW_ZONE:   cfg_q.slow_zone_pulses <= cfg_data[ZONE_W-1:0];
				CFG_SPEED_SCALE: cfg_q.speed_scale_q8   <= cfg_data[SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/eplc_core.sv =====
// counter, calibration and stop state with the per-beat next-state and result logic
// depends on eplc_pkg
module eplc_core import eplc_pkg::*; #(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    fire,
	input  item_t   item,
	input  cfg_t    cfg,
	output result_t res
);

	logic [COUNT_WIDTH-1:0] pulse_q, pulse_d, pos_q, pos_d;
	logic [LEN_W-1:0]       len_q, len_d;
	logic                   calib_q, calib_d;
	logic                   found_a_q, found_a_d, found_b_q, found_b_d;
	logic                   estop_a_q, estop_a_d, estop_b_q, estop_b_d;
	logic                   near_cw_q, near_cw_d, near_ccw_q, near_ccw_d;
	logic [TIME_W-1:0]      last_a_q, last_a_d, last_b_q, last_b_d;

	logic [COUNT_WIDTH-1:0] step, pulse_inc, pos_inc;
	logic signed [33:0]     pos_ext, lim_ext, len_ext, room_cw;
	logic [32:0]            pulse_ext, mag;
	logic [LEN_W-1:0]       len_sat;
	logic signed [POS_W-1:0] period_full;
	logic signed [56:0]     prod;
	logic                   is_a, found_sel, other_found, pass;
	logic [TIME_W-1:0]      elapsed;

	always_comb begin
		pulse_d    = pulse_q;
		pos_d      = pos_q;
		len_d      = len_q;
		calib_d    = calib_q;
		found_a_d  = found_a_q;
		found_b_d  = found_b_q;
		estop_a_d  = estop_a_q;
		estop_b_d  = estop_b_q;
		near_cw_d  = near_cw_q;
		near_ccw_d = near_ccw_q;
		last_a_d   = last_a_q;
		last_b_d   = last_b_q;

		res.period_pulses = '0;
		res.speed_um_s    = '0;
		res.speed_valid   = 1'b0;
		res.halt_pulse    = 1'b0;
		res.calib_event   = EV_NONE;

		// up when levels differ, down when equal
		step      = (item.level_a != item.level_b) ? COUNT_WIDTH'(1) : '1;
		pulse_inc = pulse_q + step;
		pos_inc   = pos_q + step;

		// slow-zone compares on the updated position, exact in 34 bits
		pos_ext = 34'($signed(pos_inc));
		lim_ext = $signed({{(34 - ZONE_W){1'b0}}, cfg.slow_zone_pulses});
		len_ext = $signed({{(34 - LEN_W){1'b0}}, len_q});
		room_cw = len_ext - pos_ext;

		// saturated magnitude of the count for the length
		pulse_ext = 33'($signed(pulse_q));
		mag       = pulse_q[COUNT_WIDTH-1] ? (33'd0 - pulse_ext) : pulse_ext;
		len_sat   = (mag[32:31] != 2'b00) ? LEN_MAX : mag[LEN_W-1:0];

		// floor of product over 256 is an arithmetic shift by 8
		period_full = POS_W'($signed(pulse_q));
		prod        = period_full * $signed({1'b0, cfg.speed_scale_q8});

		is_a        = (item.operation == OP_SW_A);
		found_sel   = is_a ? found_a_q : found_b_q;
		other_found = is_a ? found_b_q : found_a_q;
		elapsed     = item.time_us - (is_a ? last_a_q : last_b_q);
		pass        = !(elapsed < cfg.debounce_us);

		case (item.operation)
			OP_EDGE: begin
				pulse_d = pulse_inc;
				pos_d   = pos_inc;
				if (!calib_q) begin
					near_ccw_d = (pos_ext <= lim_ext);
					near_cw_d  = (room_cw <= lim_ext);
				end
			end
			OP_SW_A, OP_SW_B: begin
				if (pass) begin
					if (is_a) begin
						last_a_d = item.time_us;
					end else begin
						last_b_d = item.time_us;
					end
					if (calib_q && !found_sel) begin
						if (is_a) begin
							found_a_d = 1'b1;
						end else begin
							found_b_d = 1'b1;
						end
						if (other_found) begin
							// second end: length measured, position restarts
							len_d           = len_sat;
							calib_d         = 1'b0;
							pos_d           = '0;
							res.calib_event = EV_LENGTH;
						end else begin
							pulse_d         = '0;
							res.calib_event = EV_FIRST_END;
						end
					end else begin
						if (is_a) begin
							estop_a_d = 1'b1;
						end else begin
							estop_b_d = 1'b1;
						end
						res.halt_pulse = 1'b1;
					end
				end
			end
			OP_TICK: begin
				if (!calib_q) begin
					res.period_pulses = period_full;
					res.speed_um_s    = prod[SPEED_W+7:8];
					res.speed_valid   = 1'b1;
					pulse_d           = '0;
				end
			end
			OP_CALIB: begin
				calib_d   = 1'b1;
				found_a_d = 1'b0;
				found_b_d = 1'b0;
			end
			default: ;
		endcase

		res.calibrating = calib_d;
		res.position    = POS_W'($signed(pos_d));
		res.rope_length = len_d;
		res.slow_cw     = near_cw_d;
		res.slow_ccw    = near_ccw_d;
		res.stop_a      = estop_a_d;
		res.stop_b      = estop_b_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulse_q    <= '0;
			pos_q      <= '0;
			len_q      <= '0;
			calib_q    <= 1'b0;
			found_a_q  <= 1'b0;
			found_b_q  <= 1'b0;
			estop_a_q  <= 1'b0;
			estop_b_q  <= 1'b0;
			near_cw_q  <= 1'b0;
			near_ccw_q <= 1'b0;
			last_a_q   <= '0;
			last_b_q   <= '0;
		end else if (fire) begin
			pulse_q    <= pulse_d;
			pos_q      <= pos_d;
			len_q      <= len_d;
			calib_q    <= calib_d;
			found_a_q  <= found_a_d;
			found_b_q  <= found_b_d;
			estop_a_q  <= estop_a_d;
			estop_b_q  <= estop_b_d;
			near_cw_q  <= near_cw_d;
			near_ccw_q <= near_ccw_d;
			last_a_q   <= last_a_d;
			last_b_q   <= last_b_d;
		end
	end

endmodule

// ===== rtl/eplc_checker.sv =====
// port-level checks on the result channel of the encoder position block, with its bind
// depends on eplc_pkg and assert_macros.svh
`include "assert_macros.svh"

module eplc_assertions import eplc_pkg::*; (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic                      calibrating,
	input logic signed [POS_W-1:0]   position,
	input logic signed [POS_W-1:0]   period_pulses,
	input logic signed [SPEED_W-1:0] speed_um_s,
	input logic                      speed_valid,
	input logic                      stop_a,
	input logic                      stop_b,
	input logic                      halt_pulse,
	input logic [EV_W-1:0]           calib_event
);

	logic beat;

	assign beat = out_valid && out_ready;

	// a held result stays offered
	`ASSERT_NEXT(a_hold_valid, clk, arst_n, out_valid && !out_ready, out_valid)

	// a reported speed only comes outside calibration
	`ASSERT_IMPLIES(a_speed_not_calib, clk, arst_n, beat && speed_valid, !calibrating)

	// no tick report means zero period and speed
	`ASSERT_IMPLIES(a_quiet_tick, clk, arst_n, beat && !speed_valid,
		(period_pulses == '0) && (speed_um_s == '0))

	// a stop pulse leaves a latch set
	`ASSERT_IMPLIES(a_stop_latched, clk, arst_n, beat && halt_pulse, stop_a || stop_b)

	// measured length ends calibration at position zero
	`ASSERT_IMPLIES(a_length_done, clk, arst_n, beat && (calib_event == EV_LENGTH),
		!calibrating && (position == '0))

endmodule

bind encoder_position_limit_controller eplc_assertions u_eplc_assertions (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (results.valid),
	.out_ready     (results.ready),
	.calibrating   (results.calibrating),
	.position      (results.position),
	.period_pulses (results.period_pulses),
	.speed_um_s    (results.speed_um_s),
	.speed_valid   (results.speed_valid),
	.stop_a        (results.stop_a),
	.stop_b        (results.stop_b),
	.halt_pulse    (results.halt_pulse),
	.calib_event   (results.calib_event)
);
